FILE: rtl/abst_pkg.sv
// Package for the array binary search tree unit: sizes, codes, FSM and command types.
// No dependencies; used by abst_ctrl, abst_dp and array_bst_insert_remove_unit.
`timescale 1ns / 1ps
package abst_pkg;
	localparam int TREE_LEVELS = 10;
	localparam int SLOT_COUNT  = (1 << TREE_LEVELS) - 1;
	localparam int IDX_W       = TREE_LEVELS;      // slot index
	localparam int ADDR_W      = TREE_LEVELS + 1;  // child index, may run past the store
	localparam int KEY_W       = 32;
	localparam int OP_W        = 2;
	localparam int ST_W        = 2;
	localparam int SIDX_W      = 10;               // slot_index / last_used_slot fields
	localparam int IN_W        = 48;
	localparam int OUT_W       = 48;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT = 2'd0,
		OP_REMOVE = 2'd1,
		OP_READ   = 2'd2,
		OP_NOP    = 2'd3
	} op_t;

	typedef enum logic [ST_W-1:0] {
		ST_DONE      = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2,
		ST_ZERO_KEY  = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_CLR,       // write zero at clear counter, advance it
		CMD_LOAD,      // capture request, pos <= root
		CMD_RD_POS,    // read slot pos
		CMD_RD_IDX,    // read slot slot_index
		CMD_WR_KEY,    // write key at pos, raise last used
		CMD_DESCEND,   // pos <= child by compare, read it
		CMD_RD_LEFT,   // probe left child of pos, then walk right
		CMD_RD_RIGHT,  // probe right child of pos, then walk left
		CMD_WALK,      // accept probe, probe its next child
		CMD_MOVE,      // copy value up to pos, pos <= found, probe its left
		CMD_CLR_POS,   // clear leaf at pos, start scan below it
		CMD_SCAN_DEC,  // scan one slot lower
		CMD_SET_LAST,  // last used <= scan
		CMD_ZERO_LAST, // last used <= 0
		CMD_RESULT     // load output register
	} cmd_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_DISPATCH,
		S_RD_WAIT,
		S_INS_CHK,
		S_REM_CHK,
		S_RF_L,
		S_RF_R,
		S_RF_W,
		S_SCAN,
		S_FIN
	} state_t;

	typedef struct packed {
		cmd_t    cmd;
		status_t res;
	} dp_cmd_t;

	typedef struct packed {
		op_t  op;
		logic key_zero;
		logic rd_zero;
		logic key_eq;
		logic child_oob;
		logic pos_is_last;
		logic pos_zero;
		logic scan_zero;
		logic clr_done;
		logic out_free;
	} dp_stat_t;
endpackage

FILE: rtl/array_bst_insert_remove_unit.sv
// Top level of the array binary search tree unit.
// Depends on abst_pkg, abst_ctrl (sequencer) and abst_dp (store and datapath).
//
// Usage:
//  - Requests enter on the s_axis group (tvalid/tready/tdata); one result per request
//    leaves on the m_axis group. A request is taken when tvalid and tready are both high.
//  - Opcodes: insert key, remove key, read slot, no-op. Zero keys are rejected.
//  - One request is worked at a time; the key store has one write and one read port
//    with a registered read, and every tree step costs one read and its compare.
//  - Work per request: a read makes one store read; a no-op or rejected request makes
//    none; an insert makes one read and compare per level visited; a remove makes one
//    per search level and one per probe of the refill walk, plus, if the cleared slot
//    was the highest occupied one, a downward scan over the slots for the new highest
//    slot. Once the result is loaded the unit goes idle and can take the next request.
//  - The result sits in an output register: a new request is taken while a result
//    waits; the next result is held back until m_axis_tready frees the register.
//  - Reset: the store is cleared by a sweep over all 1023 slots, one slot a cycle; tready
//    stays low until it finishes. last_used_slot then reads zero.
`timescale 1ns / 1ps
module array_bst_insert_remove_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,  // [1:0] opcode, [33:2] key, [43:34] slot_index
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata   // [1:0] status, [33:2] slot_key, [43:34] last_used_slot
);
	import abst_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// sequencer: walks the tree one memory access at a time
	abst_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// key store, walk registers and output register
	abst_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_data   (s_axis_tdata),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata)
	);
endmodule

FILE: rtl/abst_dp.sv
// Datapath of the array BST unit: key store memory, walk registers, last-used tracking,
// output register. Depends on abst_pkg; driven by abst_ctrl commands.
`timescale 1ns / 1ps
module abst_dp (
	input  logic                   clk,
	input  logic                   arst_n,
	input  abst_pkg::dp_cmd_t      cmd,
	output abst_pkg::dp_stat_t     stat,
	input  logic [abst_pkg::IN_W-1:0]  in_data,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [abst_pkg::OUT_W-1:0] out_data
);
	import abst_pkg::*;

	logic [KEY_W-1:0]  mem [SLOT_COUNT];
	logic [KEY_W-1:0]  rd_q;
	logic              oob_q;
	logic [KEY_W-1:0]  rdata;

	op_t               op_q;
	logic [KEY_W-1:0]  key_q;
	logic [SIDX_W-1:0] idx_q;
	logic [ADDR_W-1:0] pos_q, cand_q, nxt_q;
	logic              dir_q;   // 1: walk right, 0: walk left
	logic [KEY_W-1:0]  val_q;
	logic [IDX_W-1:0]  last_q, scan_q, clr_q;
	logic              out_valid_q;
	status_t           out_st_q;
	logic [KEY_W-1:0]  out_key_q;
	logic [IDX_W-1:0]  out_last_q;

	logic [ADDR_W-1:0] child, left, right, walk_nxt, mv_left, rd_addr, wr_addr;
	logic              rd_en, wr_en;
	logic [KEY_W-1:0]  wr_data;
	logic [IDX_W-1:0]  pos_idx, scan_m1;

	assign rdata    = oob_q ? '0 : rd_q;
	assign left     = {pos_q[ADDR_W-2:0], 1'b1};
	assign right    = left + ADDR_W'(1);
	assign child    = ($signed(key_q) < $signed(rdata)) ? left : right;
	assign walk_nxt = {cand_q[ADDR_W-2:0], 1'b0} + (dir_q ? ADDR_W'(2) : ADDR_W'(1));
	assign mv_left  = {nxt_q[ADDR_W-2:0], 1'b1};
	assign pos_idx  = pos_q[IDX_W-1:0];
	assign scan_m1  = pos_idx - IDX_W'(1);

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = pos_q;
		wr_en   = 1'b0;
		wr_addr = pos_q;
		wr_data = key_q;
		unique case (cmd.cmd)
			CMD_CLR: begin
				wr_en   = 1'b1;
				wr_addr = ADDR_W'(clr_q);
				wr_data = '0;
			end
			CMD_RD_POS:   rd_en = 1'b1;
			CMD_RD_IDX: begin
				rd_en   = 1'b1;
				rd_addr = ADDR_W'(IDX_W'(idx_q));
			end
			CMD_WR_KEY:   wr_en = 1'b1;
			CMD_DESCEND: begin
				rd_en   = 1'b1;
				rd_addr = child;
			end
			CMD_RD_LEFT: begin
				rd_en   = 1'b1;
				rd_addr = left;
			end
			CMD_RD_RIGHT: begin
				rd_en   = 1'b1;
				rd_addr = right;
			end
			CMD_WALK: begin
				rd_en   = 1'b1;
				rd_addr = walk_nxt;
			end
			CMD_MOVE: begin
				wr_en   = 1'b1;
				wr_data = val_q;
				rd_en   = 1'b1;
				rd_addr = mv_left;
			end
			CMD_CLR_POS: begin
				wr_en   = 1'b1;
				wr_data = '0;
				rd_en   = 1'b1;
				rd_addr = ADDR_W'(scan_m1);
			end
			CMD_SCAN_DEC: begin
				rd_en   = 1'b1;
				rd_addr = ADDR_W'(scan_q - IDX_W'(1));
			end
			default: ;
		endcase
	end

	// key store: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr[IDX_W-1:0]] <= wr_data;
		if (rd_en) begin
			rd_q  <= mem[rd_addr[IDX_W-1:0]];
			oob_q <= (cmd.cmd == CMD_RD_IDX) ? (32'(idx_q) >= 32'(SLOT_COUNT))
			                                 : (32'(rd_addr) >= 32'(SLOT_COUNT));
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.cmd)
			CMD_LOAD: begin
				op_q  <= op_t'(in_data[OP_W-1:0]);
				key_q <= in_data[OP_W +: KEY_W];
				idx_q <= in_data[OP_W+KEY_W +: SIDX_W];
				pos_q <= '0;
			end
			CMD_DESCEND:  pos_q <= child;
			CMD_RD_LEFT: begin
				cand_q <= left;
				dir_q  <= 1'b1;
			end
			CMD_RD_RIGHT: begin
				cand_q <= right;
				dir_q  <= 1'b0;
			end
			CMD_WALK: begin
				nxt_q  <= cand_q;
				val_q  <= rdata;
				cand_q <= walk_nxt;
			end
			CMD_MOVE: begin
				pos_q  <= nxt_q;
				cand_q <= mv_left;
				dir_q  <= 1'b1;
			end
			CMD_CLR_POS:  scan_q <= scan_m1;
			CMD_SCAN_DEC: scan_q <= scan_q - IDX_W'(1);
			default: ;
		endcase
		if (cmd.cmd == CMD_RESULT) begin
			out_st_q   <= cmd.res;
			out_key_q  <= (op_q == OP_READ) ? rdata : '0;
			out_last_q <= last_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			last_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.cmd == CMD_CLR) clr_q <= clr_q + IDX_W'(1);
			unique case (cmd.cmd)
				CMD_WR_KEY:    if (pos_idx > last_q) last_q <= pos_idx;
				CMD_SET_LAST:  last_q <= scan_q;
				CMD_ZERO_LAST: last_q <= '0;
				default: ;
			endcase
			if (cmd.cmd == CMD_RESULT) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign stat.op          = op_q;
	assign stat.key_zero    = (key_q == '0);
	assign stat.rd_zero     = (rdata == '0);
	assign stat.key_eq      = (rdata == key_q);
	assign stat.child_oob   = (32'(child) >= 32'(SLOT_COUNT));
	assign stat.pos_is_last = (pos_idx == last_q);
	assign stat.pos_zero    = (pos_q == '0);
	assign stat.scan_zero   = (scan_q == '0);
	assign stat.clr_done    = (32'(clr_q) == SLOT_COUNT - 1);
	assign stat.out_free    = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_data  = {(OUT_W-ST_W-KEY_W-SIDX_W)'(0), SIDX_W'(out_last_q), out_key_q, out_st_q};
endmodule

FILE: rtl/abst_ctrl.sv
// Controller FSM of the array BST unit: sequences clear, insert, remove, read and no-op.
// Depends on abst_pkg; commands abst_dp.
`timescale 1ns / 1ps
module abst_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  abst_pkg::dp_stat_t stat,
	output abst_pkg::dp_cmd_t  cmd
);
	import abst_pkg::*;

	state_t  state_q, state_d;
	status_t res_q, res_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			res_q   <= ST_DONE;
		end else begin
			state_q <= state_d;
			res_q   <= res_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		res_d    = res_q;
		cmd.cmd  = CMD_NONE;
		cmd.res  = res_q;
		in_ready = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.cmd = CMD_CLR;
				if (stat.clr_done) state_d = S_IDLE;
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.cmd = CMD_LOAD;
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				res_d = ST_DONE;
				priority if (stat.op == OP_NOP) begin
					state_d = S_FIN;
				end else if (stat.op == OP_READ) begin
					cmd.cmd = CMD_RD_IDX;
					state_d = S_RD_WAIT;
				end else if (stat.key_zero) begin
					res_d   = ST_ZERO_KEY;
					state_d = S_FIN;
				end else begin
					cmd.cmd = CMD_RD_POS;
					state_d = (stat.op == OP_INSERT) ? S_INS_CHK : S_REM_CHK;
				end
			end
			S_RD_WAIT: state_d = S_FIN;
			S_INS_CHK: begin
				priority if (stat.rd_zero) begin
					cmd.cmd = CMD_WR_KEY;
					state_d = S_FIN;
				end else if (stat.child_oob) begin
					res_d   = ST_FULL;
					state_d = S_FIN;
				end else begin
					cmd.cmd = CMD_DESCEND;
				end
			end
			S_REM_CHK: begin
				priority if (stat.rd_zero) begin
					res_d   = ST_NOT_FOUND;
					state_d = S_FIN;
				end else if (stat.key_eq) begin
					cmd.cmd = CMD_RD_LEFT;
					state_d = S_RF_L;
				end else if (stat.child_oob) begin
					res_d   = ST_NOT_FOUND;
					state_d = S_FIN;
				end else begin
					cmd.cmd = CMD_DESCEND;
				end
			end
			S_RF_L: begin
				if (!stat.rd_zero) begin
					cmd.cmd = CMD_WALK;
					state_d = S_RF_W;
				end else begin
					cmd.cmd = CMD_RD_RIGHT;
					state_d = S_RF_R;
				end
			end
			S_RF_R: begin
				if (!stat.rd_zero) begin
					cmd.cmd = CMD_WALK;
					state_d = S_RF_W;
				end else begin
					cmd.cmd = CMD_CLR_POS;
					state_d = (stat.pos_is_last && !stat.pos_zero) ? S_SCAN : S_FIN;
				end
			end
			S_RF_W: begin
				if (!stat.rd_zero) begin
					cmd.cmd = CMD_WALK;
				end else begin
					cmd.cmd = CMD_MOVE;
					state_d = S_RF_L;
				end
			end
			S_SCAN: begin
				priority if (!stat.rd_zero) begin
					cmd.cmd = CMD_SET_LAST;
					state_d = S_FIN;
				end else if (stat.scan_zero) begin
					cmd.cmd = CMD_ZERO_LAST;
					state_d = S_FIN;
				end else begin
					cmd.cmd = CMD_SCAN_DEC;
				end
			end
			S_FIN: begin
				if (stat.out_free) begin
					cmd.cmd = CMD_RESULT;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end
endmodule

FILE: bench/testbench.sv
// Self-checking bench for array_bst_insert_remove_unit: directed and random insert/remove/read/no-op requests
// against a behavioural copy of the level-order tree. Depends on abst_pkg and the RTL top.
`timescale 1ns / 1ps
module testbench;
	import abst_pkg::*;

	localparam int NSLOT = (1 << TREE_LEVELS) - 1;

	typedef struct packed {
		status_t          st;
		logic [KEY_W-1:0] rkey;
		logic [9:0]       last;
	} tree_res_t;

	// behavioural tree plus queue of pending results
	class tree_scoreboard;
		logic [KEY_W-1:0] slots [NSLOT];
		tree_res_t pending [$];
		int errors;
		logic [KEY_W-1:0] live [$];

		function new();
			foreach (slots[i]) slots[i] = '0;
			errors = 0;
		endfunction

		function logic [KEY_W-1:0] at(int unsigned i);
			return (i < NSLOT) ? slots[i] : '0;
		endfunction

		function status_t tree_insert(logic [KEY_W-1:0] k);
			int unsigned p, c;
			p = 0;
			if (slots[0] == 0) begin
				slots[0] = k;
				return ST_DONE;
			end
			forever begin
				c = ($signed(k) < $signed(slots[p])) ? 2*p+1 : 2*p+2;
				if (c >= NSLOT) return ST_FULL;
				if (slots[c] == 0) begin
					slots[c] = k;
					return ST_DONE;
				end
				p = c;
			end
		endfunction

		function status_t tree_remove(logic [KEY_W-1:0] k);
			int unsigned p, c, nx;
			p = 0;
			forever begin
				if (slots[p] == 0) return ST_NOT_FOUND;
				if (slots[p] == k) break;
				c = ($signed(k) < $signed(slots[p])) ? 2*p+1 : 2*p+2;
				if (c >= NSLOT) return ST_NOT_FOUND;
				p = c;
			end
			// pull predecessor, else successor, down to a leaf
			forever begin
				if (at(2*p+1) != 0) begin
					nx = 2*p+1;
					while (at(2*nx+2) != 0) nx = 2*nx+2;
				end else if (at(2*p+2) != 0) begin
					nx = 2*p+2;
					while (at(2*nx+1) != 0) nx = 2*nx+1;
				end else begin
					slots[p] = 0;
					return ST_DONE;
				end
				slots[p] = slots[nx];
				p = nx;
			end
		endfunction

		function void note_request(op_t op, logic [KEY_W-1:0] k, logic [9:0] idx);
			tree_res_t r;
			int i;
			r = '0;
			r.st = ST_DONE;
			case (op)
				OP_INSERT: begin
					r.st = (k == 0) ? ST_ZERO_KEY : tree_insert(k);
					if (r.st == ST_DONE) live.push_back(k);
				end
				OP_REMOVE: r.st = (k == 0) ? ST_ZERO_KEY : tree_remove(k);
				OP_READ: r.rkey = at(idx);
				default: ;
			endcase
			for (i = NSLOT-1; i > 0; i--)
				if (slots[i] != 0) break;
			r.last = i[9:0];
			pending.push_back(r);
		endfunction

		function void check_result(logic [47:0] d);
			tree_res_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result %h", $time, d);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (d[1:0] !== e.st) begin
				$display("%0t: status exp %0d got %0d", $time, e.st, d[1:0]);
				errors++;
			end
			if (d[33:2] !== e.rkey) begin
				$display("%0t: slot_key exp %h got %h", $time, e.rkey, d[33:2]);
				errors++;
			end
			if (d[43:34] !== e.last) begin
				$display("%0t: last_used_slot exp %0d got %0d", $time, e.last, d[43:34]);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_axis_tvalid = 0;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata = '0;  // [1:0] opcode, [33:2] key, [43:34] slot_index
	logic        m_axis_tvalid;
	logic        m_axis_tready = 0;
	logic [47:0] m_axis_tdata;       // [1:0] status, [33:2] slot_key, [43:34] last_used_slot

	tree_scoreboard sb;
	int src_idle = 34, snk_idle = 84;
	bit hold_sink = 0;
	bit stim_done = 0;
	longint cycles = 0;

	always #2 clk = ~clk;

	array_bst_insert_remove_unit u_top (.*);

	// result side: random back-pressure, optional long hold
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
		m_axis_tready <= !hold_sink && ($urandom_range(99) >= snk_idle);
	end

	task automatic send(op_t op, logic [KEY_W-1:0] k, logic [9:0] idx);
		while ($urandom_range(99) < src_idle) begin
			s_axis_tvalid <= 0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tdata <= {4'b0, idx, k, op};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		sb.note_request(op, k, idx);
	endtask

	function automatic logic [KEY_W-1:0] pick_key();
		case ($urandom_range(5))
			0: return $urandom_range(40) - 20;
			1: return 32'h8000_0000 + $urandom_range(3);
			2: return 32'h7fff_ffff - $urandom_range(3);
			3: if (sb.live.size() > 0) return sb.live[$urandom_range(sb.live.size()-1)];
			default: ;
		endcase
		return $urandom;
	endfunction

	task automatic random_items(int n);
		int r;
		logic [KEY_W-1:0] k;
		repeat (n) begin
			r = $urandom_range(99);
			k = pick_key();
			if (r < 45) send(OP_INSERT, k, 10'($urandom));
			else if (r < 80) send(OP_REMOVE, k, 10'($urandom));
			else if (r < 95) send(OP_READ, $urandom, 10'($urandom_range(1023)));
			else send(OP_NOP, $urandom, 10'($urandom));
		end
	endtask

	// long hold on the result side while requests keep coming
	initial begin
		int n;
		@(posedge arst_n);
		repeat (1500) @(posedge clk);
		hold_sink = 1;
		for (n = 0; n < 300; n++) @(posedge clk);
		hold_sink = 0;
	end

	initial begin
		int i;
		sb = new();
		repeat (11) @(posedge clk);
		arst_n <= 1;
		// directed: zero keys, extremes, equal keys, misses, reads, nop
		send(OP_INSERT, 0, 0);
		send(OP_REMOVE, 0, 0);
		send(OP_REMOVE, 5, 0);
		send(OP_READ, 0, 0);
		send(OP_INSERT, 100, 0);
		send(OP_INSERT, 32'h8000_0000, 0);
		send(OP_INSERT, 32'h7fff_ffff, 0);
		send(OP_INSERT, 100, 0);
		send(OP_READ, 0, 10'd2);
		send(OP_READ, 0, 10'd1023);
		send(OP_READ, 0, 10'd1022);
		send(OP_NOP, 32'hffff_ffff, 10'h3ff);
		send(OP_REMOVE, 100, 0);
		send(OP_REMOVE, 77, 0);
		// ascending chain overruns the last level
		for (i = 1; i <= 11; i++) send(OP_INSERT, 32'h7fff_ffff - 11 + i, 0);
		send(OP_READ, 0, 10'd1022);
		send(OP_REMOVE, 32'h7fff_fff5, 0);
		random_items(600);
		src_idle = 84; snk_idle = 34;
		random_items(600);
		src_idle = 0; snk_idle = 0;
		random_items(580);
		s_axis_tvalid <= 0;
		stim_done = 1;
	end

	// run end and watchdog
	initial begin
		wait (stim_done);
		while (sb.pending.size() != 0 && cycles < 16000000) @(posedge clk);
		repeat (2000) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		wait (cycles >= 20000000);
		$display("tb: failure");
		$finish;
	end
endmodule

FILE: sim.f
rtl/abst_pkg.sv
rtl/abst_dp.sv
rtl/abst_ctrl.sv
rtl/array_bst_insert_remove_unit.sv
bench/testbench.sv
